FILE: rtl/core/ad16_pkg.sv
// ad16_pkg: shared constants, widths and codes for the 16-bit arithmetic decoder
// depends on nothing; imported by arithmetic_decoder_16bit_unit and tb_top
`timescale 1ns / 1ps
`default_nettype none

package ad16_pkg;

    localparam int CODE_BITS = 16;
    localparam int ALPHABET  = 256;

    localparam int CNT_W = 14;
    localparam int SYM_W = 9;
    localparam int IDX_W = 9;
    localparam int BU_W  = 5;
    localparam int OP_W  = 2;

    localparam int IN_FIELDS_W  = IDX_W + CNT_W + CODE_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SYM_W + BU_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_DECODE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

endpackage

`default_nettype wire

FILE: rtl/core/arithmetic_decoder_16bit_unit.sv
// arithmetic_decoder_16bit_unit: table-driven integer arithmetic decoder
// one shared restoring divider and a small sequencer; table held in a local memory
// depends on ad16_pkg
// load, start, none and idle-decode requests: result written straight into the output register
// decode request: a divider pass for the target, then table entries read in turn
//   from entry 0 (memory read port), divider passes for the low and high bounds,
//   then renormalisation unless the end symbol was decoded
// not ready while a decode request is in flight; one request at a time
// reset: interval [0, max], code value, symbol count and end flag cleared,
//   total_count 1; table contents undefined until loaded
`timescale 1ns / 1ps
`default_nettype none

module arithmetic_decoder_16bit_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // table_index, table_value, code_window
    input  logic [ad16_pkg::IN_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic [ad16_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // symbol, bits_used
    output logic [ad16_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // end_of_message
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [ad16_pkg::CNT_W-1:0]         cfg_wr_data
);
    import ad16_pkg::*;

    localparam int CB  = CODE_BITS;
    localparam int W   = CB + 16;
    localparam int NW  = CB + 15;
    localparam int DW  = CB + 1;
    localparam int KW  = $clog2(CB + 1);
    localparam int DCW = $clog2(NW + 1);

    localparam logic signed [W-1:0] HALF_C  = W'(64'd1 << (CB - 1));
    localparam logic signed [W-1:0] QTR_C   = W'(64'd1 << (CB - 2));
    localparam logic signed [W-1:0] TQTR_C  = HALF_C + QTR_C;
    localparam logic [CB-1:0]       MAX_C   = {CB{1'b1}};
    localparam logic [SYM_W-1:0]    END_SYM = SYM_W'(ALPHABET);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_TGT  = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_RD   = 9'b000001000,
        S_CHK  = 9'b000010000,
        S_MULL = 9'b000100000,
        S_MULH = 9'b001000000,
        S_REN  = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        P_TGT = 2'd0,
        P_LO  = 2'd1,
        P_HI  = 2'd2
    } phase_t;

    logic [CNT_W-1:0] table_mem [0:ALPHABET];
    logic [CNT_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CB-1:0]     low_reg, low_next;
    logic [CB-1:0]     high_reg, high_next;
    logic [CB-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]  sd_reg, sd_next;
    logic              fin_reg, fin_next;
    logic [CNT_W-1:0]  tc_reg, tc_next;
    logic [DW-1:0]     range_reg, range_next;
    logic [DW-1:0]     numb_reg, numb_next;
    logic              neg_reg, neg_next;
    logic [NW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [DCW-1:0]    dcnt_reg, dcnt_next;
    logic [NW-1:0]     tgt_reg, tgt_next;
    logic [SYM_W-1:0]  s_reg, s_next;
    logic [CNT_W-1:0]  prev_reg, prev_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic signed [W-1:0] nl_reg, nl_next;
    logic signed [W-1:0] nh_reg, nh_next;
    logic [CB-1:0]     rv_reg, rv_next;
    logic [CB-1:0]     win_reg, win_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [SYM_W-1:0]  rsym_reg, rsym_next;
    logic              reom_reg, reom_next;
    logic [BU_W-1:0]   rbu_reg, rbu_next;
    logic              ov_reg, ov_next;
    logic [SYM_W-1:0]  osym_reg, osym_next;
    logic              oeom_reg, oeom_next;
    logic [BU_W-1:0]   obu_reg, obu_next;

    logic              accept;
    op_t               in_op;
    logic [IDX_W-1:0]  in_idx;
    logic [CNT_W-1:0]  in_val;
    logic [CB-1:0]     in_win;
    logic              blocked;
    logic              ended;
    logic signed [CB+1:0] diff;
    logic signed [CB+1:0] nb;
    logic signed [CB+1:0] nb_abs;
    logic [NW-1:0]     prod_t;
    logic [NW-1:0]     prod_l;
    logic [NW-1:0]     prod_h;
    logic [DW:0]       rem_sh;
    logic              div_ge;
    logic [NW-1:0]     quo;
    logic [DW:0]       rem_sub;
    logic              le;
    logic              brk;
    logic signed [W-1:0] sub_v;
    logic signed [W-1:0] nl_s;
    logic signed [W-1:0] nh_s;
    logic [CB-1:0]     rv_s;

    assign in_op    = op_t'(s_tuser);
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_val   = s_tdata[IDX_W+CNT_W-1:IDX_W];
    assign in_win   = s_tdata[IN_FIELDS_W-1:IDX_W+CNT_W];
    assign s_tready = (state_reg == S_IDLE) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = ov_reg;
    assign m_tlast  = oeom_reg;
    assign m_tdata  = OUT_TDATA_W'({obu_reg, osym_reg});

    assign blocked = fin_reg || (({1'b0, sd_reg} + 1'b1) >= {1'b0, tc_reg});
    assign ended   = ({1'b0, sd_reg} + 1'b1) >= {1'b0, tc_reg};

    assign diff   = $signed({2'b00, high_reg}) - $signed({2'b00, low_reg})
                    + $signed((CB+2)'(1));
    assign nb     = $signed({2'b00, val_reg}) - $signed({2'b00, low_reg})
                    + $signed((CB+2)'(1));
    assign nb_abs = nb[CB+1] ? -nb : nb;

    assign prod_t = NW'(numb_reg) * NW'(tc_reg);
    assign prod_l = NW'(range_reg) * NW'(prev_reg);
    assign prod_h = NW'(range_reg) * NW'(cur_reg);

    // shared restoring divider step
    assign rem_sh  = {rem_reg, acc_reg[NW-1]};
    assign div_ge  = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign quo     = {acc_reg[NW-2:0], div_ge};

    assign le = !neg_reg && ((|tgt_reg[NW-1:CNT_W]) || (rd_data_reg <= tgt_reg[CNT_W-1:0]));

    // renormalisation step
    assign brk   = (nh_reg >= HALF_C) && !(nl_reg >= HALF_C)
                   && !((nl_reg >= QTR_C) && (nh_reg < TQTR_C));
    assign sub_v = (nh_reg >= HALF_C) ? ((nl_reg >= HALF_C) ? HALF_C : QTR_C) : '0;
    assign nl_s  = nl_reg - sub_v;
    assign nh_s  = nh_reg - sub_v;
    assign rv_s  = rv_reg - sub_v[CB-1:0];

    always_ff @(posedge clk)
    begin
        if (accept && (in_op == OP_LOAD) && (in_idx <= IDX_W'(ALPHABET)))
        begin
            table_mem[in_idx] <= in_val;
        end
        rd_data_reg <= table_mem[s_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        val_next   = val_reg;
        sd_next    = sd_reg;
        fin_next   = fin_reg;
        tc_next    = cfg_wr_en ? cfg_wr_data : tc_reg;
        range_next = range_reg;
        numb_next  = numb_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        dcnt_next  = dcnt_reg;
        tgt_next   = tgt_reg;
        s_next     = s_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        nl_next    = nl_reg;
        nh_next    = nh_reg;
        rv_next    = rv_reg;
        win_next   = win_reg;
        k_next     = k_reg;
        rsym_next  = rsym_reg;
        reom_next  = reom_reg;
        rbu_next   = rbu_reg;
        ov_next    = ov_reg && !m_tready;
        osym_next  = osym_reg;
        oeom_next  = oeom_reg;
        obu_next   = obu_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    win_next = in_win;
                    if ((in_op == OP_DECODE) && !blocked)
                    begin
                        range_next = (diff[CB+1] || (diff == 0)) ? DW'(1) : diff[DW-1:0];
                        neg_next   = nb[CB+1] || (nb == 0);
                        numb_next  = nb_abs[DW-1:0];
                        state_next = S_TGT;
                    end
                    else
                    begin
                        ov_next   = 1'b1;
                        osym_next = '0;
                        oeom_next = 1'b0;
                        obu_next  = '0;
                        if (in_op == OP_DECODE)
                        begin
                            osym_next = END_SYM;
                            oeom_next = 1'b1;
                        end
                        if (in_op == OP_START)
                        begin
                            val_next  = in_win;
                            low_next  = '0;
                            high_next = MAX_C;
                            sd_next   = '0;
                            fin_next  = 1'b0;
                        end
                    end
                end
            end
            S_TGT:
            begin
                // a negative numerator is divided by magnitude, and the target is then set to zero
                acc_next   = neg_reg ? (prod_t + 1'b1) : (prod_t - 1'b1);
                rem_next   = '0;
                div_next   = range_reg;
                dcnt_next  = DCW'(NW);
                phase_next = P_TGT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                acc_next  = quo;
                rem_next  = div_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1))
                begin
                    case (phase_reg)
                        P_TGT:
                        begin
                            tgt_next   = neg_reg ? '0 : quo;
                            neg_next   = neg_reg && (quo != '0);
                            s_next     = '0;
                            state_next = S_RD;
                        end
                        P_LO:
                        begin
                            nl_next    = $signed(W'(low_reg)) + $signed(W'(quo));
                            state_next = S_MULH;
                        end
                        P_HI:
                        begin
                            nh_next   = $signed(W'(low_reg)) + $signed(W'(quo)) - W'(1);
                            sd_next   = sd_reg + 1'b1;
                            rsym_next = s_reg;
                            if (s_reg == END_SYM)
                            begin
                                low_next   = nl_reg[CB-1:0];
                                high_next  = nh_next[CB-1:0];
                                fin_next   = 1'b1;
                                reom_next  = 1'b1;
                                rbu_next   = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rv_next    = val_reg;
                                k_next     = '0;
                                state_next = S_REN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (s_reg == '0)
                begin
                    prev_next  = rd_data_reg;
                    s_next     = SYM_W'(1);
                    state_next = S_RD;
                end
                else if ((s_reg < END_SYM) && le)
                begin
                    prev_next  = rd_data_reg;
                    s_next     = s_reg + 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cur_next   = rd_data_reg;
                    state_next = S_MULL;
                end
            end
            S_MULL:
            begin
                acc_next   = prod_l;
                rem_next   = '0;
                div_next   = DW'(tc_reg);
                dcnt_next  = DCW'(NW);
                phase_next = P_LO;
                state_next = S_DIV;
            end
            S_MULH:
            begin
                acc_next   = prod_h;
                rem_next   = '0;
                div_next   = DW'(tc_reg);
                dcnt_next  = DCW'(NW);
                phase_next = P_HI;
                state_next = S_DIV;
            end
            S_REN:
            begin
                if ((k_reg == KW'(CB)) || brk)
                begin
                    low_next   = nl_reg[CB-1:0];
                    high_next  = nh_reg[CB-1:0];
                    val_next   = rv_reg;
                    fin_next   = ended;
                    reom_next  = ended;
                    rbu_next   = BU_W'(k_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    nl_next  = $signed(W'({nl_s[CB-2:0], 1'b0}));
                    nh_next  = $signed(W'({nh_s[CB-2:0], 1'b1}));
                    rv_next  = {rv_s[CB-2:0], win_reg[CB-1]};
                    win_next = {win_reg[CB-2:0], 1'b0};
                    k_next   = k_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    osym_next  = rsym_reg;
                    oeom_next  = reom_reg;
                    obu_next   = rbu_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg   <= '0;
            high_reg  <= MAX_C;
            val_reg   <= '0;
            sd_reg    <= '0;
            fin_reg   <= 1'b0;
            tc_reg    <= CNT_W'(1);
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            val_reg   <= val_next;
            sd_reg    <= sd_next;
            fin_reg   <= fin_next;
            tc_reg    <= tc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        range_reg <= range_next;
        numb_reg  <= numb_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        dcnt_reg  <= dcnt_next;
        tgt_reg   <= tgt_next;
        s_reg     <= s_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        nl_reg    <= nl_next;
        nh_reg    <= nh_next;
        rv_reg    <= rv_next;
        win_reg   <= win_next;
        k_reg     <= k_next;
        rsym_reg  <= rsym_next;
        reom_reg  <= reom_next;
        rbu_reg   <= rbu_next;
        osym_reg  <= osym_next;
        oeom_reg  <= oeom_next;
        obu_reg   <= obu_next;
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for arithmetic_decoder_16bit_unit
// drives load, start, decode and none requests on the stream input and checks every result
// against an in-bench decoder model; depends on ad16_pkg and the decoder rtl
`timescale 1ns / 1ps

class decode_scoreboard;

    typedef struct {
        logic [8:0] symbol;
        logic       eom;
        logic [4:0] bits_used;
    } decode_result_t;

    localparam longint MAXV  = 65535;
    localparam longint QTR   = MAXV / 4 + 1;
    localparam longint HALF  = 2 * QTR;
    localparam longint TQTR  = 3 * QTR;

    longint         cum_tab [0:256];
    longint         total;
    longint         lo_b;
    longint         hi_b;
    longint         code_reg;
    longint         n_decoded;
    bit             done;
    decode_result_t awaited [$];
    int             errors;

    function new();
        foreach (cum_tab[i]) cum_tab[i] = 0;
        total     = 1;
        lo_b      = 0;
        hi_b      = MAXV;
        code_reg  = 0;
        n_decoded = 0;
        done      = 0;
        errors    = 0;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function void report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (request %0d outstanding)",
                 what, got, want, awaited.size());
        errors++;
    endfunction

    function void note_request(ad16_pkg::op_t op, int idx, int tval, int window);
        decode_result_t r;
        longint rng;
        longint tgt;
        longint nl;
        longint nh;
        longint v;
        int     s;
        int     k;
        int     b;
        r.symbol    = 0;
        r.eom       = 0;
        r.bits_used = 0;
        case (op)
            ad16_pkg::OP_LOAD:
                if (idx <= 256) cum_tab[idx] = tval;
            ad16_pkg::OP_START:
            begin
                code_reg  = window;
                lo_b      = 0;
                hi_b      = MAXV;
                n_decoded = 0;
                done      = 0;
            end
            ad16_pkg::OP_DECODE:
            begin
                if (done || n_decoded + 1 >= total)
                begin
                    r.symbol = 256;
                    r.eom    = 1;
                end
                else
                begin
                    v   = code_reg;
                    rng = hi_b - lo_b + 1;
                    if (rng < 1) rng = 1;
                    tgt = ((v - lo_b + 1) * total - 1) / rng;
                    s = 1;
                    while (s < 256 && cum_tab[s] <= tgt) s++;
                    nl = lo_b + (rng * cum_tab[s-1]) / total;
                    nh = lo_b + (rng * cum_tab[s]) / total - 1;
                    n_decoded = (n_decoded + 1) & 14'h3fff;
                    r.symbol = s;
                    if (s == 256)
                    begin
                        lo_b   = nl & MAXV;
                        hi_b   = nh & MAXV;
                        done   = 1;
                        r.eom  = 1;
                    end
                    else
                    begin
                        for (k = 0; k < 16; k++)
                        begin
                            if (nh >= HALF)
                            begin
                                if (nl >= HALF)
                                begin
                                    v -= HALF; nl -= HALF; nh -= HALF;
                                end
                                else if (nl >= QTR && nh < TQTR)
                                begin
                                    v -= QTR; nl -= QTR; nh -= QTR;
                                end
                                else
                                    break;
                            end
                            b  = (window >> (15 - k)) & 1;
                            nl = (2 * nl) & MAXV;
                            nh = (2 * nh + 1) & MAXV;
                            v  = ((2 * v) & MAXV) | b;
                        end
                        lo_b     = nl & MAXV;
                        hi_b     = nh & MAXV;
                        code_reg = v & MAXV;
                        if (n_decoded + 1 >= total) done = 1;
                        r.eom       = done;
                        r.bits_used = k;
                    end
                end
            end
            default: ;
        endcase
        awaited.push_back(r);
    endfunction

    function void check_result(logic [8:0] sym, logic eom, logic [4:0] bu);
        decode_result_t w;
        if (awaited.size() == 0)
        begin
            report("unexpected result, symbol", sym, -1);
            return;
        end
        w = awaited.pop_front();
        if (sym !== w.symbol) report("symbol", sym, w.symbol);
        if (eom !== w.eom) report("end_of_message", eom, w.eom);
        if (bu !== w.bits_used) report("bits_used", bu, w.bits_used);
    endfunction

endclass

module tb_top;
    import ad16_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]         s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;
    logic                    cfg_wr_en;
    logic [CNT_W-1:0]        cfg_wr_data;

    decode_scoreboard sb = new();
    int     send_idle_pct;
    int     recv_stall_pct;
    longint cycles;
    int     n_sent;

    arithmetic_decoder_16bit_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // result side: random back-pressure, check on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[8:0], m_tlast, m_tdata[13:9]);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(op_t op, int idx, int tval, int window);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, window[15:0], tval[13:0], idx[8:0]};
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, idx, tval, window);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_total(int v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.total = v;
    endtask

    // monotone cumulative table ending at tc, any remainder goes to the end symbol
    task automatic load_table(int tc);
        int c;
        int s;
        c = 0;
        send_request(OP_LOAD, 0, 0, $urandom_range(65535));
        for (s = 1; s <= 256; s++)
        begin
            if (s == 256)
                c = (tc > 0) ? tc : 0;
            else if ($urandom_range(3) == 0 && tc > c)
                c = c + $urandom_range(0, (tc - c) / 3);
            send_request(OP_LOAD, s, c, $urandom_range(65535));
        end
    endtask

    task automatic message(int len);
        send_request(OP_START, $urandom_range(511), $urandom_range(16383),
                     $urandom_range(65535));
        repeat (len)
            send_request(OP_DECODE, $urandom_range(511), $urandom_range(16383),
                         $urandom_range(65535));
    endtask

    task automatic random_phase(int quota);
        int r;
        n_sent = 0;
        while (n_sent < quota)
        begin
            r = $urandom_range(99);
            if (r < 78)
                message($urandom_range(1, 24));
            else if (r < 84)
                send_request(OP_NONE, $urandom_range(511), $urandom_range(16383),
                             $urandom_range(65535));
            else if (r < 90)
                send_request(OP_LOAD, $urandom_range(257, 511), $urandom_range(16383),
                             $urandom_range(65535));
            else if (r < 96)
                send_request(OP_DECODE, $urandom_range(511), $urandom_range(16383),
                             $urandom_range(65535));
            else
                // corrupts the table until the next reload
                send_request(OP_LOAD, $urandom_range(256), $urandom_range(16383),
                             $urandom_range(65535));
            if ($urandom_range(49) == 0)
                drain();
        end
    endtask

    initial
    begin
        int p;
        int tc;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = OP_NONE;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycles         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed; decodes before the table load have no step left
        send_request(OP_DECODE, 0, 0, 16'hffff);
        send_request(OP_NONE, 511, 16383, 16'hffff);
        send_request(OP_LOAD, 300, 16383, 0);
        send_request(OP_LOAD, 511, 16383, 16'hffff);
        send_request(OP_START, 0, 0, 16'hffff);
        send_request(OP_DECODE, 0, 0, 0);
        write_total(0);
        send_request(OP_START, 0, 0, 16'h8000);
        send_request(OP_DECODE, 0, 0, 16'h1234);
        write_total(16383);
        load_table(16383);
        send_request(OP_START, 0, 0, 0);
        repeat (3) send_request(OP_DECODE, 0, 0, 0);
        send_request(OP_START, 0, 0, 16'hffff);
        repeat (3) send_request(OP_DECODE, 0, 0, 16'hffff);
        write_total(2);
        send_request(OP_START, 0, 0, 16'h5a5a);
        repeat (2) send_request(OP_DECODE, 0, 0, 16'ha5a5);

        // random phases: none, sender idle, receiver stall, both
        for (p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1) ? 86 : (p == 3) ? 17 : 0;
            recv_stall_pct = (p == 2) ? 86 : (p == 3) ? 17 : 0;
            case (p)
                0: tc = 16383;
                1: tc = $urandom_range(2, 40);
                2: tc = $urandom_range(3, 16383);
                default: tc = $urandom_range(1, 600);
            endcase
            write_total(tc);
            // first phase keeps the table loaded for 16383 above
            if (p != 0)
                load_table(tc);
            random_phase(185);
        end

        drain();
        repeat (700) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
